// ===== rtl/telnet_receive_negotiator_top_defines.svh =====
// Assertion macros shared by the telnet receive negotiator RTL.
`ifndef TELNET_RECEIVE_NEGOTIATOR_TOP_DEFINES_SVH
`define TELNET_RECEIVE_NEGOTIATOR_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Check a property on every rising clock edge outside reset.
`define TNRN_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("telnet receive negotiator: check failed");
// Same, with a message of the caller's choice.
`define TNRN_ASSERT_MSG(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);
`else
`define TNRN_ASSERT(lbl, prop)
`define TNRN_ASSERT_MSG(lbl, prop, msg)
`endif

`endif

// ===== rtl/tnrn_pkg.sv =====
// Types, protocol constants and byte tables of the telnet receive negotiator.
`default_nettype none
package tnrn_pkg;

  localparam logic [7:0] C_SE   = 8'd240;
  localparam logic [7:0] C_AYT  = 8'd246;
  localparam logic [7:0] C_SB   = 8'd250;
  localparam logic [7:0] C_WILL = 8'd251;
  localparam logic [7:0] C_WONT = 8'd252;
  localparam logic [7:0] C_DO   = 8'd253;
  localparam logic [7:0] C_DONT = 8'd254;
  localparam logic [7:0] C_IAC  = 8'd255;

  localparam logic [7:0] BINARY_OPT    = 8'd0;
  localparam logic [7:0] WINSIZE_OPT   = 8'd31;
  localparam logic [7:0] SUB_TTYPE     = 8'd24;
  localparam logic [7:0] TERM_SEND_CMD = 8'd1;
  localparam logic [7:0] NAWS_ROWS     = 8'd25;

  localparam int unsigned NUM_OPTS = 5;
  localparam int unsigned NAWS_IDX = 4;
  localparam int unsigned AYT_MAX  = 15;
  localparam int unsigned TTYPE_LEN = 11;

  // Bit i belongs to tracked option i (binary, echo, SGA, ttype, NAWS).
  localparam logic [NUM_OPTS-1:0] ACCEPT_LOCAL = 5'b11101;
  localparam logic [NUM_OPTS-1:0] ACCEPT_PEER  = 5'b00111;

  localparam logic DEST_LOCAL = 1'b0;
  localparam logic DEST_PEER  = 1'b1;

  // Register indexes of the configuration port.
  localparam logic REG_START_MODE = 1'b0;
  localparam logic REG_INIT_COLS  = 1'b1;

  localparam logic [1:0] MODE_ACTIVE = 2'd1;
  localparam logic [1:0] MODE_AUTO   = 2'd2;

  typedef enum logic [2:0] {
    JOB_BYTE,
    JOB_REPLY,
    JOB_REPLY_NAWS,
    JOB_NAWS,
    JOB_TTYPE,
    JOB_AYT
  } job_kind_e;

  // One unit of work handed from the parser to the sequencer.
  typedef struct packed {
    job_kind_e  kind;
    logic       dest;
    logic [7:0] data;
    logic [7:0] verb;
    logic [7:0] cols;
    logic       binary;
    logic       active;
  } job_t;

  function automatic logic [7:0] opt_code(input logic [2:0] idx);
    logic [7:0] r;
    case (idx)
      3'd0:    r = 8'd0;
      3'd1:    r = 8'd1;
      3'd2:    r = 8'd3;
      3'd3:    r = 8'd24;
      3'd4:    r = 8'd31;
      default: r = 8'd0;
    endcase
    return r;
  endfunction

  // NAWS packet byte j; a width of 255 is doubled on the wire.
  function automatic logic [7:0] naws_byte(input logic [3:0] j, input logic [7:0] cols);
    logic [3:0] jj;
    logic [7:0] r;
    jj = ((cols != C_IAC) && (j >= 4'd5)) ? j + 4'd1 : j;
    case (jj)
      4'd0:    r = C_IAC;
      4'd1:    r = C_SB;
      4'd2:    r = WINSIZE_OPT;
      4'd3:    r = 8'd0;
      4'd4:    r = cols;
      4'd5:    r = C_IAC;
      4'd6:    r = 8'd0;
      4'd7:    r = NAWS_ROWS;
      4'd8:    r = C_IAC;
      4'd9:    r = C_SE;
      default: r = 8'd0;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] ttype_byte(input logic [3:0] k);
    logic [7:0] r;
    case (k)
      4'd0:    r = C_IAC;
      4'd1:    r = C_SB;
      4'd2:    r = SUB_TTYPE;
      4'd3:    r = 8'd0;
      4'd4:    r = 8'd86;
      4'd5:    r = 8'd84;
      4'd6:    r = 8'd49;
      4'd7:    r = 8'd48;
      4'd8:    r = 8'd50;
      4'd9:    r = C_IAC;
      4'd10:   r = C_SE;
      default: r = 8'd0;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] ayt_byte(input logic [3:0] k);
    logic [7:0] r;
    case (k)
      4'd0:    r = 8'd13;
      4'd1:    r = 8'd10;
      4'd2:    r = 8'd91;
      4'd3:    r = 8'd117;
      4'd4:    r = 8'd108;
      4'd5:    r = 8'd121;
      4'd6:    r = 8'd116;
      4'd7:    r = 8'd105;
      4'd8:    r = 8'd116;
      4'd9:    r = 8'd101;
      4'd10:   r = 8'd114;
      4'd11:   r = 8'd109;
      4'd12:   r = 8'd93;
      4'd13:   r = 8'd13;
      4'd14:   r = 8'd10;
      default: r = 8'd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/tnrn_front.sv =====
// Parser front end: IAC state machine, option negotiation state, job issue.
`default_nettype none
module tnrn_front import tnrn_pkg::*; #(
  parameter int unsigned SUB_BUF_DEPTH = 16
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output      logic       in_stall_o,
  input  wire logic       command_i,
  input  wire logic [7:0] rx_byte_i,
  input  wire logic       first_in_buffer_i,
  input  wire logic [7:0] new_columns_i,
  input  wire logic       cfg_valid_i,
  input  wire logic       cfg_index_i,
  input  wire logic [7:0] cfg_data_i,
  input  wire logic       q_full_i,
  output      logic       q_push_o,
  output      job_t       job_o
);

  localparam int unsigned SCW = $clog2(SUB_BUF_DEPTH + 1);

  localparam logic [2:0] P_DATA   = 3'd0;
  localparam logic [2:0] P_IAC    = 3'd1;
  localparam logic [2:0] P_VERB   = 3'd2;
  localparam logic [2:0] P_SUB    = 3'd3;
  localparam logic [2:0] P_SUBIAC = 3'd4;

  logic [2:0]     state_q, state_d;
  logic [7:0]     verb_q, verb_d;
  logic [1:0]     mode_q;
  logic           active_q, active_d;
  logic           binary_q, binary_d;
  logic [7:0]     cols_q, cols_d;
  logic [3:0]     opt_q [NUM_OPTS];
  logic [3:0]     opt_d [NUM_OPTS];
  logic [SCW-1:0] sub_cnt_q, sub_cnt_d;
  logic [7:0]     head0_q, head0_d, head1_q, head1_d;

  logic       accept;
  logic       do_store;
  logic [7:0] store_byte;
  logic       hit;
  logic [2:0] idx;
  logic       on;
  logic [3:0] f;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  always_comb begin
    hit = 1'b0;
    idx = 3'd0;
    for (int i = 0; i < NUM_OPTS; i++) begin
      if (opt_code(3'(i)) == rx_byte_i) begin
        hit = 1'b1;
        idx = 3'(i);
      end
    end
  end

  always_comb begin
    state_d    = state_q;
    verb_d     = verb_q;
    active_d   = active_q;
    binary_d   = binary_q;
    cols_d     = cols_q;
    opt_d      = opt_q;
    sub_cnt_d  = sub_cnt_q;
    head0_d    = head0_q;
    head1_d    = head1_q;
    do_store   = 1'b0;
    store_byte = rx_byte_i;
    on         = 1'b0;
    f          = opt_q[idx];
    q_push_o   = 1'b0;
    job_o      = '0;
    job_o.kind = JOB_BYTE;
    job_o.dest = DEST_PEER;
    job_o.data = rx_byte_i;

    if (command_i) begin
      cols_d = new_columns_i;
      if (opt_q[NAWS_IDX][0]) begin
        q_push_o   = 1'b1;
        job_o.kind = JOB_NAWS;
      end
    end else begin
      if (!active_q && mode_q == MODE_AUTO && first_in_buffer_i && rx_byte_i == C_IAC) begin
        active_d = 1'b1;
      end
      if (!active_d) begin
        q_push_o   = 1'b1;
        job_o.dest = DEST_LOCAL;
      end else begin
        case (state_q)
          P_IAC: begin
            state_d = P_DATA;
            if (rx_byte_i == C_IAC) begin
              q_push_o   = 1'b1;
              job_o.dest = DEST_LOCAL;
            end else if (rx_byte_i >= C_WILL && rx_byte_i <= C_DONT) begin
              verb_d  = rx_byte_i;
              state_d = P_VERB;
            end else if (rx_byte_i == C_SB) begin
              sub_cnt_d = '0;
              state_d   = P_SUB;
            end else if (rx_byte_i == C_AYT) begin
              q_push_o   = 1'b1;
              job_o.kind = JOB_AYT;
            end
          end
          P_VERB: begin
            state_d = P_DATA;
            if (!hit) begin
              // Refuse what we do not track; silence on WONT/DONT.
              if (verb_q == C_WILL) begin
                q_push_o   = 1'b1;
                job_o.kind = JOB_REPLY;
                job_o.verb = C_DONT;
              end else if (verb_q == C_DO) begin
                q_push_o   = 1'b1;
                job_o.kind = JOB_REPLY;
                job_o.verb = C_WONT;
              end
            end else if (verb_q == C_DO || verb_q == C_DONT) begin
              on = (verb_q == C_DO) && ACCEPT_LOCAL[idx];
              if (!((f[0] == on) && f[1])) begin
                opt_d[idx] = {f[3:2], 1'b1, on};
                q_push_o   = 1'b1;
                job_o.kind = (on && rx_byte_i == WINSIZE_OPT) ? JOB_REPLY_NAWS : JOB_REPLY;
                job_o.verb = on ? C_WILL : C_WONT;
                if (rx_byte_i == BINARY_OPT) begin
                  binary_d = on;
                end
              end
            end else begin
              on = (verb_q == C_WILL) && ACCEPT_PEER[idx];
              if (!((f[2] == on) && f[3])) begin
                opt_d[idx] = {1'b1, on, f[1:0]};
                q_push_o   = 1'b1;
                job_o.kind = JOB_REPLY;
                job_o.verb = on ? C_DO : C_DONT;
              end
            end
          end
          P_SUB: begin
            if (rx_byte_i == C_IAC) begin
              state_d = P_SUBIAC;
            end else begin
              do_store = 1'b1;
            end
          end
          P_SUBIAC: begin
            if (rx_byte_i == C_IAC) begin
              do_store   = 1'b1;
              store_byte = C_IAC;
              state_d    = P_SUB;
            end else begin
              state_d = P_DATA;
              if (rx_byte_i == C_SE && sub_cnt_q != '0) begin
                if (head0_q == SUB_TTYPE && sub_cnt_q > SCW'(1) &&
                    head1_q == TERM_SEND_CMD) begin
                  q_push_o   = 1'b1;
                  job_o.kind = JOB_TTYPE;
                end else if (head0_q == WINSIZE_OPT) begin
                  q_push_o   = 1'b1;
                  job_o.kind = JOB_NAWS;
                end
              end
            end
          end
          default: begin
            state_d = P_DATA;
            if (rx_byte_i == C_IAC) begin
              state_d = P_IAC;
            end else begin
              q_push_o   = 1'b1;
              job_o.dest = DEST_LOCAL;
            end
          end
        endcase
      end
    end

    // Keep the first two subnegotiation bytes, saturate the count.
    if (do_store && sub_cnt_q < SCW'(SUB_BUF_DEPTH)) begin
      if (sub_cnt_q == SCW'(0)) begin
        head0_d = store_byte;
      end
      if (sub_cnt_q == SCW'(1)) begin
        head1_d = store_byte;
      end
      sub_cnt_d = sub_cnt_q + SCW'(1);
    end

    job_o.cols   = cols_d;
    job_o.binary = binary_d;
    job_o.active = active_d;
    q_push_o     = q_push_o && accept;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= P_DATA;
      verb_q    <= '0;
      mode_q    <= '0;
      active_q  <= 1'b0;
      binary_q  <= 1'b0;
      cols_q    <= 8'd80;
      sub_cnt_q <= '0;
      head0_q   <= '0;
      head1_q   <= '0;
      for (int i = 0; i < NUM_OPTS; i++) begin
        opt_q[i] <= '0;
      end
    end else if (cfg_valid_i) begin
      if (cfg_index_i == REG_START_MODE) begin
        mode_q   <= cfg_data_i[1:0];
        active_q <= (cfg_data_i[1:0] == MODE_ACTIVE);
      end else begin
        cols_q <= cfg_data_i;
      end
    end else if (accept) begin
      state_q   <= state_d;
      verb_q    <= verb_d;
      active_q  <= active_d;
      binary_q  <= binary_d;
      cols_q    <= cols_d;
      sub_cnt_q <= sub_cnt_d;
      head0_q   <= head0_d;
      head1_q   <= head1_d;
      opt_q     <= opt_d;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/tnrn_queue.sv =====
// Small job queue between the parser and the byte sequencer.
`default_nettype none
module tnrn_queue import tnrn_pkg::*; #(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire job_t push_job_i,
  input  wire logic pop_i,
  output      job_t head_o,
  output      logic full_o,
  output      logic empty_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  job_t          mem_q [DEPTH];
  logic [PW-1:0] wr_q, rd_q;
  logic [CW-1:0] cnt_q;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/tnrn_back.sv =====
// Byte sequencer: expands queued jobs into result bytes behind an output register.
`default_nettype none
module tnrn_back import tnrn_pkg::*; #(
  parameter int unsigned AYT_LEN = 15
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire job_t       head_i,
  input  wire logic       empty_i,
  output      logic       pop_o,
  output      logic       out_valid_o,
  input  wire logic       out_stall_i,
  output      logic       destination_o,
  output      logic [7:0] out_byte_o,
  output      logic       last_o,
  output      logic       binary_transmit_o,
  output      logic       link_active_o
);

  localparam int unsigned AYT_N = (AYT_LEN < AYT_MAX) ? AYT_LEN : AYT_MAX;

  logic [3:0] k_q;
  logic       valid_q;
  logic       dest_q, last_q, bin_q, act_q;
  logic [7:0] byte_q;

  logic       load;
  logic       dest_c, last_c;
  logic [7:0] byte_c;
  logic [3:0] naws_last;

  assign naws_last = (head_i.cols == C_IAC) ? 4'd9 : 4'd8;
  assign load      = !empty_i && (!valid_q || !out_stall_i);
  assign pop_o     = load && last_c;

  always_comb begin
    dest_c = DEST_PEER;
    byte_c = 8'd0;
    last_c = 1'b0;
    case (head_i.kind)
      JOB_BYTE: begin
        dest_c = head_i.dest;
        byte_c = head_i.data;
        last_c = 1'b1;
      end
      JOB_REPLY, JOB_REPLY_NAWS: begin
        if (k_q == 4'd0) begin
          byte_c = C_IAC;
        end else if (k_q == 4'd1) begin
          byte_c = head_i.verb;
        end else if (k_q == 4'd2) begin
          byte_c = head_i.data;
        end else begin
          byte_c = naws_byte(k_q - 4'd3, head_i.cols);
        end
        if (head_i.kind == JOB_REPLY) begin
          last_c = (k_q == 4'd2);
        end else begin
          last_c = (k_q == naws_last + 4'd3);
        end
      end
      JOB_NAWS: begin
        byte_c = naws_byte(k_q, head_i.cols);
        last_c = (k_q == naws_last);
      end
      JOB_TTYPE: begin
        byte_c = ttype_byte(k_q);
        last_c = (k_q == 4'(TTYPE_LEN - 1));
      end
      JOB_AYT: begin
        byte_c = ayt_byte(k_q);
        last_c = (k_q == 4'(AYT_N - 1));
      end
      default: begin
        last_c = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q     <= '0;
      valid_q <= 1'b0;
    end else begin
      if (load) begin
        valid_q <= 1'b1;
        k_q     <= last_c ? 4'd0 : k_q + 4'd1;
      end else if (!out_stall_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      dest_q <= dest_c;
      byte_q <= byte_c;
      last_q <= last_c;
      bin_q  <= head_i.binary;
      act_q  <= head_i.active;
    end
  end

  assign out_valid_o       = valid_q;
  assign destination_o     = dest_q;
  assign out_byte_o        = byte_q;
  assign last_o            = last_q;
  assign binary_transmit_o = bin_q;
  assign link_active_o     = act_q;

endmodule
`default_nettype wire

// ===== rtl/telnet_receive_negotiator_top.sv =====
// Top level of the telnet receive negotiator: parser, job queue and sequencer.
`default_nettype none
`include "telnet_receive_negotiator_top_defines.svh"
// Telnet receive negotiator. Received bytes (command 0) and window resize
// requests (command 1) enter on the input channel, one request per cycle
// unless stalled. The parser classifies each request in the cycle it is
// accepted, updates its IAC parse state, option negotiation flags, binary
// and link flags, and queues at most one job: a single local data byte, a
// three-byte reply (optionally followed by a NAWS packet), a NAWS packet,
// the terminal-type packet or the are-you-there text. The sequencer
// drains the queue one result byte per cycle unless stalled, into a
// registered output; last marks the final byte of a request, and
// binary_transmit/link_active show the flags as they stand after that
// request. A multi-byte job holds the sequencer until its last byte is out
// (3 bytes for a reply, 9 or 10 for NAWS, 11 for terminal type, up
// to 15 for the are-you-there text). The QUEUE_DEPTH-entry job queue lets
// the input keep flowing during such a burst; in_stall_o rises only when
// the queue is full. Requests that produce nothing never enter the queue.
// The configuration port (cfg_ready_o always high) takes register 0,
// start_mode (0 passthrough, 1 telnet active, 2 activate on an IAC that
// starts a buffer; writing it reloads link_active), and register 1, the
// initial column count reported in NAWS (writing it reloads the current
// width). Write configuration only while no request is in flight.
module telnet_receive_negotiator_top import tnrn_pkg::*; #(
  parameter int unsigned SUB_BUF_DEPTH = 16,
  parameter int unsigned AYT_LEN       = 15,
  parameter int unsigned QUEUE_DEPTH   = 4
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output      logic       in_stall_o,
  input  wire logic       command_i,
  input  wire logic [7:0] rx_byte_i,
  input  wire logic       first_in_buffer_i,
  input  wire logic [7:0] new_columns_i,
  output      logic       out_valid_o,
  input  wire logic       out_stall_i,
  output      logic       destination_o,
  output      logic [7:0] out_byte_o,
  output      logic       last_o,
  output      logic       binary_transmit_o,
  output      logic       link_active_o,
  input  wire logic       cfg_valid_i,
  output      logic       cfg_ready_o,
  input  wire logic       cfg_index_i,
  input  wire logic [7:0] cfg_data_i
);

  logic q_push, q_pop, q_full, q_empty;
  job_t push_job, head_job;

  // Configuration is always taken at once.
  assign cfg_ready_o = 1'b1;

  tnrn_front #(
    .SUB_BUF_DEPTH(SUB_BUF_DEPTH)
  ) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .command_i        (command_i),
    .rx_byte_i        (rx_byte_i),
    .first_in_buffer_i(first_in_buffer_i),
    .new_columns_i    (new_columns_i),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .q_full_i         (q_full),
    .q_push_o         (q_push),
    .job_o            (push_job)
  );

  tnrn_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (q_push),
    .push_job_i(push_job),
    .pop_i     (q_pop),
    .head_o    (head_job),
    .full_o    (q_full),
    .empty_o   (q_empty)
  );

  tnrn_back #(
    .AYT_LEN(AYT_LEN)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .head_i           (head_job),
    .empty_i          (q_empty),
    .pop_o            (q_pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .destination_o    (destination_o),
    .out_byte_o       (out_byte_o),
    .last_o           (last_o),
    .binary_transmit_o(binary_transmit_o),
    .link_active_o    (link_active_o)
  );

  // The parser never writes a full queue, the sequencer never pops an empty one.
  `TNRN_ASSERT(a_no_overflow, q_push |-> !q_full)
  `TNRN_ASSERT(a_no_underflow, q_pop |-> !q_empty)
  // Local terminal bytes are always a single result of their request.
  `TNRN_ASSERT_MSG(a_local_single, (out_valid_o && destination_o == DEST_LOCAL) |-> last_o,
    "local byte not marked last")

endmodule
`default_nettype wire

// ===== verif/telnet_receive_negotiator_checker.sv =====
// Channel monitor with its own model of the telnet negotiator: predicts every output byte.
module telnet_receive_negotiator_checker import tnrn_pkg::*; #(
  parameter int unsigned SUB_BUF_DEPTH = 16,
  parameter int unsigned AYT_LEN       = 15
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_stall_i,
  input  logic       command_i,
  input  logic [7:0] rx_byte_i,
  input  logic       first_in_buffer_i,
  input  logic [7:0] new_columns_i,
  input  logic       out_valid_i,
  input  logic       out_stall_i,
  input  logic       destination_i,
  input  logic [7:0] out_byte_i,
  input  logic       last_i,
  input  logic       binary_transmit_i,
  input  logic       link_active_i,
  input  logic       cfg_valid_i,
  input  logic       cfg_ready_i,
  input  logic       cfg_index_i,
  input  logic [7:0] cfg_data_i,
  output int         fail_count_o,
  output int         pending_o,
  output int         requests_o,
  output int         results_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_BURST = 15;
  // Bits of the per-option negotiation state.
  localparam int US_ON    = 0;
  localparam int US_ANS   = 1;
  localparam int PEER_ON  = 2;
  localparam int PEER_ANS = 3;

  localparam logic [7:0] TRACKED_OPTS [NUM_OPTS] = '{8'd0, 8'd1, 8'd3, 8'd24, 8'd31};
  localparam logic [7:0] AYT_TEXT [15] = '{8'd13, 8'd10, 8'd91, 8'd117, 8'd108, 8'd121,
                                          8'd116, 8'd105, 8'd116, 8'd101, 8'd114, 8'd109,
                                          8'd93, 8'd13, 8'd10};
  localparam logic [7:0] TTYPE_REPLY [TTYPE_LEN] = '{C_IAC, C_SB, SUB_TTYPE, 8'd0, 8'd86,
                                                    8'd84, 8'd49, 8'd48, 8'd50, C_IAC, C_SE};

  typedef enum logic [2:0] {PS_DATA, PS_IAC, PS_VERB, PS_SUB, PS_SUB_IAC} parse_e;

  typedef struct {
    logic       dest;
    logic [7:0] data;
    logic       last;
    logic       binary;
    logic       active;
  } out_byte_t;

  parse_e     parse_st;
  logic [7:0] held_verb;
  logic       link_on;
  logic       binary_on;
  logic [1:0] mode_reg;
  logic [7:0] cols_now;
  logic [3:0] opt_st [NUM_OPTS];
  int         sub_len;
  logic [7:0] sub_first [2];
  out_byte_t  burst [$];
  out_byte_t  owed_q [$];
  int         fails = 0;
  int         requests = 0;
  int         results = 0;

  function automatic void put(logic dest, logic [7:0] data);
    out_byte_t r;
    r = '{dest, data, 1'b0, 1'b0, 1'b0};
    if (burst.size() < MAX_BURST) burst.push_back(r);
  endfunction

  function automatic void put3(logic [7:0] verb, logic [7:0] opt);
    put(DEST_PEER, C_IAC);
    put(DEST_PEER, verb);
    put(DEST_PEER, opt);
  endfunction

  function automatic void put_naws();
    put(DEST_PEER, C_IAC);
    put(DEST_PEER, C_SB);
    put(DEST_PEER, WINSIZE_OPT);
    put(DEST_PEER, 8'd0);
    put(DEST_PEER, cols_now);
    if (cols_now == C_IAC) put(DEST_PEER, C_IAC);
    put(DEST_PEER, 8'd0);
    put(DEST_PEER, NAWS_ROWS);
    put(DEST_PEER, C_IAC);
    put(DEST_PEER, C_SE);
  endfunction

  // Keep the first two subnegotiation bytes, count up to the buffer depth.
  function automatic void keep_sub(logic [7:0] c);
    if (sub_len < SUB_BUF_DEPTH) begin
      if (sub_len < 2) sub_first[sub_len] = c;
      sub_len++;
    end
  endfunction

  function automatic void predict_request(logic cmd, logic [7:0] c, logic first,
                                          logic [7:0] cols);
    int   idx;
    logic on;
    burst.delete();
    if (cmd) begin
      cols_now = cols;
      if (opt_st[NAWS_IDX][US_ON]) put_naws();
    end else begin
      if (!link_on && mode_reg == MODE_AUTO && first && c == C_IAC) link_on = 1'b1;
      if (!link_on) begin
        put(DEST_LOCAL, c);
      end else begin
        case (parse_st)
          PS_IAC: begin
            parse_st = PS_DATA;
            if (c == C_IAC) begin
              put(DEST_LOCAL, C_IAC);
            end else if (c >= C_WILL && c <= C_DONT) begin
              held_verb = c;
              parse_st = PS_VERB;
            end else if (c == C_SB) begin
              sub_len = 0;
              parse_st = PS_SUB;
            end else if (c == C_AYT) begin
              for (int k = 0; k < AYT_LEN && k < MAX_BURST; k++) put(DEST_PEER, AYT_TEXT[k]);
            end
          end
          PS_VERB: begin
            parse_st = PS_DATA;
            idx = -1;
            for (int k = 0; k < NUM_OPTS; k++) if (TRACKED_OPTS[k] == c) idx = k;
            if (idx < 0) begin
              // refuse what we do not track; negative verbs need no answer
              if (held_verb == C_WILL) put3(C_DONT, c);
              else if (held_verb == C_DO) put3(C_WONT, c);
            end else if (held_verb == C_DO || held_verb == C_DONT) begin
              on = (held_verb == C_DO) && ACCEPT_LOCAL[idx];
              if (!(opt_st[idx][US_ANS] && opt_st[idx][US_ON] == on)) begin
                opt_st[idx][US_ON] = on;
                opt_st[idx][US_ANS] = 1'b1;
                put3(on ? C_WILL : C_WONT, c);
                if (on && c == WINSIZE_OPT) put_naws();
                if (c == BINARY_OPT) binary_on = on;
              end
            end else begin
              on = (held_verb == C_WILL) && ACCEPT_PEER[idx];
              if (!(opt_st[idx][PEER_ANS] && opt_st[idx][PEER_ON] == on)) begin
                opt_st[idx][PEER_ON] = on;
                opt_st[idx][PEER_ANS] = 1'b1;
                put3(on ? C_DO : C_DONT, c);
              end
            end
          end
          PS_SUB: begin
            if (c == C_IAC) parse_st = PS_SUB_IAC;
            else keep_sub(c);
          end
          PS_SUB_IAC: begin
            if (c == C_IAC) begin
              keep_sub(C_IAC);
              parse_st = PS_SUB;
            end else begin
              parse_st = PS_DATA;
              if (c == C_SE && sub_len > 0) begin
                if (sub_first[0] == SUB_TTYPE && sub_len > 1 &&
                    sub_first[1] == TERM_SEND_CMD) begin
                  for (int k = 0; k < TTYPE_LEN; k++) put(DEST_PEER, TTYPE_REPLY[k]);
                end else if (sub_first[0] == WINSIZE_OPT) begin
                  put_naws();
                end
              end
            end
          end
          default: begin
            if (c == C_IAC) parse_st = PS_IAC;
            else put(DEST_LOCAL, c);
          end
        endcase
      end
    end
    foreach (burst[k]) begin
      burst[k].last = (k == burst.size() - 1);
      burst[k].binary = binary_on;
      burst[k].active = link_on;
      owed_q.push_back(burst[k]);
    end
  endfunction

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fails++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : track
    out_byte_t want;
    if (!rst_ni) begin
      parse_st = PS_DATA;
      held_verb = 8'd0;
      mode_reg = 2'd0;
      link_on = 1'b0;
      binary_on = 1'b0;
      cols_now = 8'd80;
      foreach (opt_st[k]) opt_st[k] = 4'd0;
      sub_len = 0;
      sub_first[0] = 8'd0;
      sub_first[1] = 8'd0;
      owed_q.delete();
    end else begin
      // compare first so a byte can never match a request taken at the same edge
      if (out_valid_i && !out_stall_i) begin
        results++;
        if (owed_q.size() == 0) begin
          $error("unexpected result: destination %0d, out_byte %0d", destination_i, out_byte_i);
          fails++;
        end else begin
          want = owed_q.pop_front();
          check_field("destination", 8'(want.dest), 8'(destination_i));
          check_field("out_byte", want.data, out_byte_i);
          check_field("last", 8'(want.last), 8'(last_i));
          check_field("binary_transmit", 8'(want.binary), 8'(binary_transmit_i));
          check_field("link_active", 8'(want.active), 8'(link_active_i));
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == REG_START_MODE) begin
          mode_reg = cfg_data_i[1:0];
          link_on = (mode_reg == MODE_ACTIVE);
        end else begin
          cols_now = cfg_data_i;
        end
      end
      if (in_valid_i && !in_stall_i) begin
        requests++;
        predict_request(command_i, rx_byte_i, first_in_buffer_i, new_columns_i);
      end
    end
    fail_count_o <= fails;
    pending_o <= owed_q.size();
    requests_o <= requests;
    results_o <= results;
  end

endmodule

// ===== verif/tb_telnet_receive_negotiator_top.sv =====
// Stimulus and verdict for the telnet receive negotiator, with the checker beside the block.
module tb_telnet_receive_negotiator_top;
  import tnrn_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // Start modes beyond the two the package names: plain passthrough and the
  // unused fourth code, which must also behave as passthrough.
  localparam logic [1:0] MODE_PASS     = 2'd0;
  localparam logic [1:0] MODE_PASS_ALT = 2'd3;
  // Tracked options that the package leaves unnamed.
  localparam logic [7:0] ECHO_OPT     = 8'd1;
  localparam logic [7:0] SGA_OPT      = 8'd3;
  localparam logic [7:0] TERMTYPE_OPT = 8'd24;
  localparam logic [7:0] OPT_LIST [5] = '{BINARY_OPT, ECHO_OPT, SGA_OPT, TERMTYPE_OPT,
                                          WINSIZE_OPT};
  localparam logic [7:0] OPT_UNTRACKED = 8'd99;
  localparam int HOLD_CYCLES = 300;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic       command = 1'b0;
  logic [7:0] rx_byte = 8'd0;
  logic       first_in_buffer = 1'b0;
  logic [7:0] new_columns = 8'd0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       destination;
  logic [7:0] out_byte;
  logic       last;
  logic       binary_transmit;
  logic       link_active;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic       cfg_index = 1'b0;
  logic [7:0] cfg_data = 8'd0;

  int   fail_count;
  int   pending_results;
  int   requests_seen;
  int   results_seen;
  int   sent = 0;
  int   reg_writes = 0;
  // steady: neither side idles; hold_req asks the sink for one long hold-off
  logic steady = 1'b0;
  logic hold_req = 1'b0;
  logic hold_done = 1'b0;

  telnet_receive_negotiator_top dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .command_i        (command),
    .rx_byte_i        (rx_byte),
    .first_in_buffer_i(first_in_buffer),
    .new_columns_i    (new_columns),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .destination_o    (destination),
    .out_byte_o       (out_byte),
    .last_o           (last),
    .binary_transmit_o(binary_transmit),
    .link_active_o    (link_active),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data)
  );

  telnet_receive_negotiator_checker u_negotiation_check (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .command_i        (command),
    .rx_byte_i        (rx_byte),
    .first_in_buffer_i(first_in_buffer),
    .new_columns_i    (new_columns),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .destination_i    (destination),
    .out_byte_i       (out_byte),
    .last_i           (last),
    .binary_transmit_i(binary_transmit),
    .link_active_i    (link_active),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_i      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .fail_count_o     (fail_count),
    .pending_o        (pending_results),
    .requests_o       (requests_seen),
    .results_o        (results_seen)
  );

  always #5 clk = ~clk;

  // Offer one request at the falling edge and hold it until the block takes
  // it, then idle for a random gap: mostly none, sometimes short, rarely a
  // long stretch.
  task automatic push_req(logic cmd, logic [7:0] b, logic first, logic [7:0] cols);
    int r;
    int gap;
    @(negedge clk);
    in_valid <= 1'b1;
    command <= cmd;
    rx_byte <= b;
    first_in_buffer <= first;
    new_columns <= cols;
    do @(posedge clk); while (in_stall);
    sent++;
    if (!steady) begin
      r = $urandom_range(0, 99);
      gap = (r < 55) ? 0 : (r < 90) ? $urandom_range(1, 3) : $urandom_range(4, 25);
      repeat (gap) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
    end
  endtask

  // Received byte; the unused columns field still carries random bits.
  task automatic push_byte(logic [7:0] b, logic first);
    push_req(1'b0, b, first, 8'($urandom_range(0, 255)));
  endtask

  task automatic push_resize(logic [7:0] cols);
    push_req(1'b1, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), cols);
  endtask

  task automatic write_reg(logic idx, logic [7:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    reg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Drop valid and drain: wait until every predicted byte is out, then give
  // the block a few more cycles before the next step.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_mode(logic [1:0] mode, logic [7:0] cols);
    settle();
    write_reg(REG_START_MODE, {6'd0, mode});
    write_reg(REG_INIT_COLS, cols);
  endtask

  // One telnet construct with random content. Most are well formed so the
  // parser gets past its first states; the rest are stray commands, broken
  // subnegotiations and raw noise.
  task automatic random_sequence();
    int         kind;
    int         n;
    logic [7:0] v;
    logic       f;
    kind = $urandom_range(0, 99);
    f = ($urandom_range(0, 2) == 0);
    if (kind < 22) begin
      push_byte(8'($urandom_range(0, 254)), f);
    end else if (kind < 27) begin
      push_byte(C_IAC, f);
      push_byte(C_IAC, 1'b0);
    end else if (kind < 57) begin
      // negotiation: mostly tracked options, some untracked ones
      v = ($urandom_range(0, 9) < 7) ? OPT_LIST[$urandom_range(0, 4)]
                                     : 8'($urandom_range(0, 255));
      push_byte(C_IAC, f);
      push_byte(8'(C_WILL + $urandom_range(0, 3)), 1'b0);
      push_byte(v, 1'b0);
    end else if (kind < 62) begin
      push_byte(C_IAC, f);
      push_byte(C_AYT, 1'b0);
    end else if (kind < 78) begin
      push_byte(C_IAC, f);
      push_byte(C_SB, 1'b0);
      case ($urandom_range(0, 3))
        0: begin
          push_byte(SUB_TTYPE, 1'b0);
          push_byte(TERM_SEND_CMD, 1'b0);
        end
        1: push_byte(WINSIZE_OPT, 1'b0);
        2: push_byte(SUB_TTYPE, 1'b0);
        default: ;
      endcase
      // occasionally overrun the subnegotiation buffer
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 20) : $urandom_range(0, 3);
      repeat (n) begin
        v = 8'($urandom_range(0, 255));
        push_byte(v, 1'b0);
        if (v == C_IAC) push_byte(C_IAC, 1'b0);
      end
      push_byte(C_IAC, 1'b0);
      // mostly a proper end; otherwise abort with some other command
      push_byte(($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 254)) : C_SE, 1'b0);
    end else if (kind < 83) begin
      push_byte(C_IAC, f);
      push_byte(8'($urandom_range(0, 255)), 1'b0);
    end else if (kind < 91) begin
      push_resize(8'($urandom_range(0, 255)));
    end else begin
      push_byte(8'($urandom_range(0, 255)), f);
    end
  endtask

  task automatic random_phase(int count);
    int target;
    target = sent + count;
    while (sent < target) random_sequence();
  endtask

  // Sink pacing: stall in runs of random length, mostly short, a few long,
  // plus one long hold-off on request so the job queue fills and the input
  // stalls.
  initial begin : sink_pacing
    int span;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (hold_req && !hold_done) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done = 1'b1;
      end else if (!steady && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        span = ($urandom_range(0, 6) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
        repeat (span) @(negedge clk);
      end else begin
        out_stall <= 1'b0;
        span = $urandom_range(1, 12);
        repeat (span) @(negedge clk);
      end
    end
  end

  initial begin : stimulus
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Passthrough after reset: extremes go straight to the local side, a
    // buffer-leading IAC does not activate, and a resize is silent.
    push_byte(8'h00, 1'b0);
    push_byte(C_IAC, 1'b1);
    push_resize(8'h5A);

    // Fourth start-mode code: still passthrough, no automode.
    set_mode(MODE_PASS_ALT, 8'd255);
    push_byte(C_IAC, 1'b1);

    // Automode: an IAC in mid-buffer passes through; one that starts a
    // buffer switches telnet on and is parsed as a command prefix.
    settle();
    write_reg(REG_START_MODE, {6'd0, MODE_AUTO});
    push_byte(C_IAC, 1'b0);
    push_byte(C_IAC, 1'b1);
    push_byte(C_AYT, 1'b0);
    // doubled IAC is data
    push_byte(C_IAC, 1'b0);
    push_byte(C_IAC, 1'b0);
    // accept NAWS: reply plus NAWS with width 255, which gets escaped
    push_byte(C_IAC, 1'b0);
    push_byte(C_DO, 1'b0);
    push_byte(WINSIZE_OPT, 1'b0);
    // binary on flips the flag seen on every result
    push_byte(C_IAC, 1'b0);
    push_byte(C_DO, 1'b0);
    push_byte(BINARY_OPT, 1'b0);
    // refuse an untracked option
    push_byte(C_IAC, 1'b0);
    push_byte(C_WILL, 1'b0);
    push_byte(OPT_UNTRACKED, 1'b0);
    // terminal-type request
    push_byte(C_IAC, 1'b0);
    push_byte(C_SB, 1'b0);
    push_byte(SUB_TTYPE, 1'b0);
    push_byte(TERM_SEND_CMD, 1'b0);
    push_byte(C_IAC, 1'b0);
    push_byte(C_SE, 1'b0);
    // resize while NAWS is on resends the packet, here at width zero
    push_resize(8'd0);

    // Telnet on, zero width. Open with a burst of AYT requests while the
    // sink holds off, so the job queue fills and the input has to stall.
    set_mode(MODE_ACTIVE, 8'd0);
    hold_req = 1'b1;
    repeat (12) begin
      push_byte(C_IAC, 1'b0);
      push_byte(C_AYT, 1'b0);
    end
    random_phase(40);

    set_mode(MODE_AUTO, 8'($urandom_range(0, 255)));
    random_phase(35);

    // Passthrough at full width, both sides running flat out.
    set_mode(MODE_PASS, 8'd255);
    steady = 1'b1;
    random_phase(15);
    steady = 1'b0;

    set_mode(MODE_ACTIVE, 8'($urandom_range(0, 255)));
    random_phase(60);

    // Drain with the sink open, then allow time for any stray bytes.
    @(negedge clk);
    in_valid <= 1'b0;
    steady = 1'b1;
    do @(posedge clk); while (pending_results != 0);
    repeat (60) @(posedge clk);

    $display("Run covered %0d requests and %0d result bytes over %0d register writes,",
             requests_seen, results_seen, reg_writes);
    $display("including a %0d-cycle sink hold-off that backed up the input.", HOLD_CYCLES);
    if (fail_count == 0) begin
      $display("** telnet_receive_negotiator_top: PASSED **");
    end else begin
      $display("** telnet_receive_negotiator_top: FAILED **");
    end
    $finish;
  end

  // Generous bound: many times the slowest legal run.
  initial begin : watchdog
    #(10_000_000);
    $display("Timeout with %0d result bytes still outstanding.", pending_results);
    $display("** telnet_receive_negotiator_top: FAILED **");
    $finish;
  end

endmodule
